// File: rtl/core/assert_macros.svh
// Assertion macros used by the point transform datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/ptt_pkg.sv
// Package: shared types, codes and the sine table builder for the point transform.
package ptt_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int APB_ADDR_W  = 5;
	localparam int DEG_HALF_TURN = 180;
	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	// Operation codes; code 3 passes the vertex through
	typedef enum logic [1:0] {
		OP_TRANSLATE = 2'd0,
		OP_SCALE     = 2'd1,
		OP_ROTATE    = 2'd2
	} op_t;

	// Register indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_OPERATION = 3'd0,
		REG_OFFSET_X  = 3'd1,
		REG_OFFSET_Y  = 3'd2,
		REG_FACTOR_X  = 3'd3,
		REG_FACTOR_Y  = 3'd4,
		REG_ANGLE_DEG = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] px;
		logic signed [COORD_WIDTH-1:0] py;
		logic                          last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic               last_out;
	} out_item_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
		logic signed [15:0] factor_x;
		logic signed [15:0] factor_y;
		logic [8:0]         angle_deg;
	} cfg_t;

	// sin(d degrees) in Q30 from an eleven-term series, clamped to [0, 1].
	// Only evaluated at elaboration to fill the table.
	function automatic longint unsigned sine_q30(input int unsigned d);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x    = longint'(d) * PI_Q30 / DEG_HALF_TURN;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd342; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd420; sum = sum + longint'(term);
		if (sum < 0)
			sum = 0;
		if (sum > longint'(ONE_Q30))
			sum = longint'(ONE_Q30);
		return longint'(sum);
	endfunction

endpackage

// File: rtl/core/ptt_regs.sv
// APB register file holding the transform configuration.
module ptt_regs
	import ptt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.operation <= OP_TRANSLATE;
			cfg_q.offset_x  <= 16'sd0;
			cfg_q.offset_y  <= 16'sd0;
			cfg_q.factor_x  <= 16'sd1;
			cfg_q.factor_y  <= 16'sd1;
			cfg_q.angle_deg <= 9'd0;
		end else if (wr_en) begin
			case (idx)
				REG_OPERATION: cfg_q.operation <= pwdata[1:0];
				REG_OFFSET_X:  cfg_q.offset_x  <= pwdata[15:0];
				REG_OFFSET_Y:  cfg_q.offset_y  <= pwdata[15:0];
				REG_FACTOR_X:  cfg_q.factor_x  <= pwdata[15:0];
				REG_FACTOR_Y:  cfg_q.factor_y  <= pwdata[15:0];
				REG_ANGLE_DEG: cfg_q.angle_deg <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// Read mux, zero-extended
	always_comb begin
		case (idx)
			REG_OPERATION: prdata = {30'd0, cfg_q.operation};
			REG_OFFSET_X:  prdata = {16'd0, cfg_q.offset_x};
			REG_OFFSET_Y:  prdata = {16'd0, cfg_q.offset_y};
			REG_FACTOR_X:  prdata = {16'd0, cfg_q.factor_x};
			REG_FACTOR_Y:  prdata = {16'd0, cfg_q.factor_y};
			REG_ANGLE_DEG: prdata = {23'd0, cfg_q.angle_deg};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

// File: rtl/core/ptt_trig.sv
// Sine/cosine coefficient lookup for the configured rotation angle.
module ptt_trig
	import ptt_pkg::*;
#(
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic [8:0]                    angle_deg,
	output logic signed [TRIG_FRAC_BITS+1:0] sin_coef,
	output logic signed [TRIG_FRAC_BITS+1:0] cos_coef
);

	localparam int TW  = TRIG_FRAC_BITS + 1;
	localparam int CTW = TRIG_FRAC_BITS + 2;

	typedef logic [TW-1:0] sine_tab_t [91];

	// Quarter-wave table, rounded to TRIG_FRAC_BITS fraction bits
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t       t;
		longint unsigned v;
		for (int d = 0; d <= 90; d++) begin
			v    = sine_q30(d);
			t[d] = TW'((v + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	logic [8:0]             deg;
	logic [1:0]             quad;
	logic [6:0]             rem;
	logic signed [CTW-1:0]  sa;
	logic signed [CTW-1:0]  sb;
	logic signed [CTW-1:0]  s_nx;
	logic signed [CTW-1:0]  c_nx;
	logic signed [CTW-1:0]  sin_q;
	logic signed [CTW-1:0]  cos_q;

	// Fold angle into one turn and split into quadrant and remainder
	always_comb begin
		deg = (angle_deg >= 9'd360) ? angle_deg - 9'd360 : angle_deg;
		if (deg inside {[9'd0:9'd89]}) begin
			quad = 2'd0;
			rem  = deg[6:0];
		end else if (deg inside {[9'd90:9'd179]}) begin
			quad = 2'd1;
			rem  = 7'(deg - 9'd90);
		end else if (deg inside {[9'd180:9'd269]}) begin
			quad = 2'd2;
			rem  = 7'(deg - 9'd180);
		end else begin
			quad = 2'd3;
			rem  = 7'(deg - 9'd270);
		end
	end

	// Table reads and quadrant symmetry
	always_comb begin
		sa = $signed({1'b0, SINE_TAB[rem]});
		sb = $signed({1'b0, SINE_TAB[7'd90 - rem]});
		case (quad)
			2'd0: begin s_nx = sa;  c_nx = sb;  end
			2'd1: begin s_nx = sb;  c_nx = -sa; end
			2'd2: begin s_nx = -sa; c_nx = -sb; end
			default: begin s_nx = -sb; c_nx = sa; end
		endcase
	end

	// Coefficients refresh every cycle; the angle is to change only while idle, which the block does not enforce
	always_ff @(posedge clk) begin
		sin_q <= s_nx;
		cos_q <= c_nx;
	end

	assign sin_coef = sin_q;
	assign cos_coef = cos_q;

endmodule

// File: rtl/core/ptt_datapath.sv
// Four-stage vertex pipeline: capture, multiply, combine, finish.
`include "assert_macros.svh"

module ptt_datapath
	import ptt_pkg::*;
#(
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  in_item_t                         in_item,
	input  cfg_t                             cfg,
	input  logic signed [TRIG_FRAC_BITS+1:0] sin_coef,
	input  logic signed [TRIG_FRAC_BITS+1:0] cos_coef,
	output logic                             out_valid,
	output out_item_t                        out_item
);

	localparam int BW = (TRIG_FRAC_BITS + 2 > 16) ? TRIG_FRAC_BITS + 2 : 16;
	localparam int PW = COORD_WIDTH + BW;
	localparam int SW = PW + 1;
	localparam logic signed [SW-1:0] RND = SW'((1 << TRIG_FRAC_BITS) - 1);

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic                          last_s1, last_s2, last_s3;
	logic signed [PW-1:0]          m0_s2, m1_s2, m2_s2, m3_s2;
	logic signed [SW-1:0]          sx_s3, sy_s3;
	out_item_t                     res_s4;

	logic signed [BW-1:0] b0, b1, b2, b3;
	logic signed [SW-1:0] tx, ty;
	out_item_t            res_nx;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Multiplier operands: x*b0 - y*b1 and x*b2 + y*b3
	always_comb begin
		case (cfg.operation)
			OP_SCALE: begin
				b0 = BW'(cfg.factor_x);
				b1 = '0;
				b2 = '0;
				b3 = BW'(cfg.factor_y);
			end
			OP_ROTATE: begin
				b0 = BW'(cos_coef);
				b1 = BW'(sin_coef);
				b2 = BW'(sin_coef);
				b3 = BW'(cos_coef);
			end
			default: begin
				b0 = '0;
				b1 = '0;
				b2 = '0;
				b3 = '0;
			end
		endcase
	end

	// Rotation truncates toward zero
	always_comb begin
		tx = (sx_s3 + (sx_s3[SW-1] ? RND : SW'(0))) >>> TRIG_FRAC_BITS;
		ty = (sy_s3 + (sy_s3[SW-1] ? RND : SW'(0))) >>> TRIG_FRAC_BITS;
		res_nx.last_out = last_s3;
		case (cfg.operation)
			OP_TRANSLATE: begin
				res_nx.qx = 32'(x_s3) + 32'(cfg.offset_x);
				res_nx.qy = 32'(y_s3) + 32'(cfg.offset_y);
			end
			OP_SCALE: begin
				res_nx.qx = sx_s3[31:0];
				res_nx.qy = sy_s3[31:0];
			end
			OP_ROTATE: begin
				res_nx.qx = tx[31:0];
				res_nx.qy = ty[31:0];
			end
			default: begin
				res_nx.qx = 32'(x_s3);
				res_nx.qy = 32'(y_s3);
			end
		endcase
	end

	// Payload stages
	always_ff @(posedge clk) begin
		x_s1    <= in_item.px;
		y_s1    <= in_item.py;
		last_s1 <= in_item.last_in;

		m0_s2   <= x_s1 * b0;
		m1_s2   <= y_s1 * b1;
		m2_s2   <= x_s1 * b2;
		m3_s2   <= y_s1 * b3;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		last_s2 <= last_s1;

		sx_s3   <= SW'(m0_s2) - SW'(m1_s2);
		sy_s3   <= SW'(m2_s2) + SW'(m3_s2);
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		last_s3 <= last_s2;

		res_s4  <= res_nx;
	end

	assign out_valid = v_s4;
	assign out_item  = res_s4;

	// Checks
	`ASSERT_IMPL(a_latency, clk, arst_n, in_valid, ##4 out_valid)
	`ASSERT_IMPL(a_no_phantom, clk, arst_n, out_valid, $past(in_valid, 4))
	`ASSERT_IMPL(a_last_kept, clk, arst_n, out_valid, out_item.last_out == $past(in_item.last_in, 4))
	`ASSERT_NEXT(a_zero_offset, clk, arst_n, v_s3 && (cfg.operation == OP_TRANSLATE) && (cfg.offset_x == 16'sd0), out_item.qx == 32'($past(x_s3)))

endmodule

// File: rtl/core/point_2d_transform_unit.sv
// Top level of the 2-D point transform: APB configuration plus vertex pipeline.
//
// One vertex per clock in, one transformed vertex per clock out. An item is taken
// when start is high (busy is never raised), and its result appears on result
// with done high once it has passed through the pipeline stages in order
// (input capture, four multipliers, add/subtract, truncation and output select).
// Results are not held: the receiver must take result in the cycle done is high.
// Operation selects translate, scale, rotate, or pass-through for code 3. The
// rotation coefficients are registered in the cycle after the angle register; the
// user must write configuration only while no vertex is in flight; not enforced.
module point_2d_transform_unit
	import ptt_pkg::*;
#(
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              vertex,
	output logic                  done,
	output out_item_t             result
);

	cfg_t                             cfg;
	logic signed [TRIG_FRAC_BITS+1:0] sin_coef;
	logic signed [TRIG_FRAC_BITS+1:0] cos_coef;

	// Fully pipelined, so a new item is always taken
	assign busy = 1'b0;

	ptt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ptt_trig #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_trig (
		.clk       (clk),
		.angle_deg (cfg.angle_deg),
		.sin_coef  (sin_coef),
		.cos_coef  (cos_coef)
	);

	ptt_datapath #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_item   (vertex),
		.cfg       (cfg),
		.sin_coef  (sin_coef),
		.cos_coef  (cos_coef),
		.out_valid (done),
		.out_item  (result)
	);

endmodule

// File: tb/tb_point_2d_transform_unit.sv
// Testbench for point_2d_transform_unit: APB setup, vertex stream, result scoreboard.
module tb_point_2d_transform_unit;
	import ptt_pkg::*;

	localparam int FRAC_BITS    = 14;
	localparam int RANDOM_ITEMS = 1900;
	localparam int LATENCY      = 4;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_PRINTED  = 60;

	// Operation code 3 is not in the package enum: the vertex passes through
	localparam logic [1:0] OP_PASS = 2'd3;
	// Register slots past the last one; writes there must be ignored
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [31:0]           pwdata  = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  start   = 1'b0;
	logic                  busy;
	in_item_t              vertex  = '0;
	logic                  done;
	out_item_t             result;

	int unsigned cycle_count = 0;

	// Predicts each transformed vertex and checks the results in order
	class vertex_scoreboard;
		cfg_t      regs;
		longint    sine_q14[0:90];
		out_item_t expected_q[$];
		int        errors;
		int        checked;
		int        op_count[4];

		function new();
			regs.operation = OP_TRANSLATE;
			regs.offset_x  = '0;
			regs.offset_y  = '0;
			regs.factor_x  = 16'sd1;
			regs.factor_y  = 16'sd1;
			regs.angle_deg = '0;
			errors  = 0;
			checked = 0;
			foreach (op_count[k])
				op_count[k] = 0;
			build_sine_table();
		endfunction

		// sin(d) for d in 0..90, Q30 odd series rounded to the trig fraction width
		function void build_sine_table();
			longint unsigned ang;
			longint unsigned ang2;
			longint unsigned term;
			longint          sum;
			bit              neg;
			for (int d = 0; d <= 90; d++) begin
				ang  = longint'(d) * PI_Q30 / DEG_HALF_TURN;
				ang2 = (ang * ang) >> 30;
				term = ang;
				sum  = longint'(ang);
				neg  = 1'b1;
				for (int n = 3; n <= 21; n += 2) begin
					term = (term * ang2) >> 30;
					term = term / longint'((n - 1) * n);
					if (neg)
						sum = sum - longint'(term);
					else
						sum = sum + longint'(term);
					neg = !neg;
				end
				if (sum < 0)
					sum = 0;
				if (sum > longint'(ONE_Q30))
					sum = longint'(ONE_Q30);
				sine_q14[d] = (sum + (longint'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
			end
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_OPERATION: regs.operation = data[1:0];
				REG_OFFSET_X:  regs.offset_x  = data[15:0];
				REG_OFFSET_Y:  regs.offset_y  = data[15:0];
				REG_FACTOR_X:  regs.factor_x  = data[15:0];
				REG_FACTOR_Y:  regs.factor_y  = data[15:0];
				REG_ANGLE_DEG: regs.angle_deg = data[8:0];
				default: ;
			endcase
		endfunction

		function out_item_t transform(in_item_t v);
			out_item_t   r;
			longint      x;
			longint      y;
			longint      rx;
			longint      ry;
			longint      s;
			longint      c;
			int unsigned d;
			int unsigned quad;
			int unsigned rem;
			x  = longint'(v.px);
			y  = longint'(v.py);
			rx = x;
			ry = y;
			case (regs.operation)
				OP_TRANSLATE: begin
					rx = x + longint'(regs.offset_x);
					ry = y + longint'(regs.offset_y);
				end
				OP_SCALE: begin
					rx = x * longint'(regs.factor_x);
					ry = y * longint'(regs.factor_y);
				end
				OP_ROTATE: begin
					d    = regs.angle_deg % 360;
					quad = d / 90;
					rem  = d % 90;
					case (quad)
						0: begin s =  sine_q14[rem];      c =  sine_q14[90 - rem]; end
						1: begin s =  sine_q14[90 - rem]; c = -sine_q14[rem];      end
						2: begin s = -sine_q14[rem];      c = -sine_q14[90 - rem]; end
						default: begin s = -sine_q14[90 - rem]; c = sine_q14[rem]; end
					endcase
					// signed division truncates toward zero
					rx = (x * c - y * s) / (longint'(1) << FRAC_BITS);
					ry = (x * s + y * c) / (longint'(1) << FRAC_BITS);
				end
				default: ;
			endcase
			r.qx       = rx[31:0];
			r.qy       = ry[31:0];
			r.last_out = v.last_in;
			return r;
		endfunction

		function void note_vertex(in_item_t v);
			expected_q.push_back(transform(v));
			op_count[regs.operation]++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("MISMATCH %0d at cycle %0d: %s", errors, cycle_count, msg);
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			checked++;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result qx=%0d qy=%0d", got.qx, got.qy));
				return;
			end
			want = expected_q.pop_front();
			if (got.qx !== want.qx)
				report($sformatf("qx got %0d want %0d", got.qx, want.qx));
			if (got.qy !== want.qy)
				report($sformatf("qy got %0d want %0d", got.qy, want.qy));
			if (got.last_out !== want.last_out)
				report($sformatf("last_out got %b want %b", got.last_out, want.last_out));
		endtask
	endclass

	vertex_scoreboard sb;

	point_2d_transform_unit #(
		.TRIG_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.vertex  (vertex),
		.done    (done),
		.result  (result)
	);

	// 20-unit clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Timeout after %0d cycles", cycle_count);
		$display("Simulation FAILED");
		$finish;
	end

	// Result monitor: a result is valid only in its done cycle
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_result(result);
	end

	// APB write; the bus then idles before the task returns
	task automatic apb_write(logic [2:0] idx, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// APB read, compared on the register's own width
	task automatic apb_check_reg(logic [2:0] idx, logic [31:0] want, int width);
		logic [31:0] mask;
		mask    = (32'd1 << width) - 32'd1;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (want & mask))
			sb.report($sformatf("register %0d read 0x%0h want 0x%0h", idx, prdata & mask,
				want & mask));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write every register with junk in the unused upper bits, then read back
	task automatic program_regs(cfg_t c);
		logic [31:0] junk;
		junk = $urandom;
		apb_write(REG_OPERATION, {junk[31:2], c.operation});
		junk = $urandom;
		apb_write(REG_OFFSET_X, {junk[31:16], c.offset_x});
		junk = $urandom;
		apb_write(REG_OFFSET_Y, {junk[31:16], c.offset_y});
		junk = $urandom;
		apb_write(REG_FACTOR_X, {junk[31:16], c.factor_x});
		junk = $urandom;
		apb_write(REG_FACTOR_Y, {junk[31:16], c.factor_y});
		junk = $urandom;
		apb_write(REG_ANGLE_DEG, {junk[31:9], c.angle_deg});
		if ($urandom_range(0, 3) == 0)
			apb_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
		apb_check_reg(REG_OPERATION, 32'(c.operation), 2);
		apb_check_reg(REG_OFFSET_X, 32'(c.offset_x), 16);
		apb_check_reg(REG_OFFSET_Y, 32'(c.offset_y), 16);
		apb_check_reg(REG_FACTOR_X, 32'(c.factor_x), 16);
		apb_check_reg(REG_FACTOR_Y, 32'(c.factor_y), 16);
		apb_check_reg(REG_ANGLE_DEG, 32'(c.angle_deg), 9);
	endtask

	// Present one vertex, wait for it to be taken, then idle for gap cycles
	task automatic send_vertex(in_item_t v, int gap);
		start  <= 1'b1;
		vertex <= v;
		do @(posedge clk); while (busy);
		sb.note_vertex(v);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every pending vertex has come back
	task automatic drain();
		if (sb.pending() != 0) begin
			start <= 1'b0;
			while (sb.pending() != 0)
				@(posedge clk);
		end
	endtask

	function automatic in_item_t make_vertex(logic signed [15:0] x, logic signed [15:0] y,
		logic last);
		in_item_t v;
		v.px      = x;
		v.py      = y;
		v.last_in = last;
		return v;
	endfunction

	// Mostly full-range values, with extremes and values near zero
	function automatic logic signed [15:0] rand_coord();
		logic signed [15:0] val;
		case ($urandom_range(0, 9))
			0: val = 16'sh8000;
			1: val = 16'sh7fff;
			2: val = 16'($signed($urandom_range(0, 16)) - 8);
			default: val = 16'($urandom);
		endcase
		return val;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int gap_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	function automatic cfg_t random_setting();
		cfg_t c;
		int   pick;
		pick = $urandom_range(0, 9);
		if (pick < 3)
			c.operation = OP_TRANSLATE;
		else if (pick < 6)
			c.operation = OP_SCALE;
		else if (pick < 9)
			c.operation = OP_ROTATE;
		else
			c.operation = OP_PASS;
		c.offset_x  = rand_coord();
		c.offset_y  = rand_coord();
		c.factor_x  = rand_coord();
		c.factor_y  = rand_coord();
		c.angle_deg = 9'($urandom_range(0, 511));
		return c;
	endfunction

	// Stimulus
	initial begin
		int          sent;
		int          directed_items;
		int          settings;
		int          phase_items;
		bit          burst;
		bit          flip;
		cfg_t        c;
		int unsigned angles[8];

		sb = new();
		angles = '{90, 180, 270, 45, 359, 360, 449, 511};
		settings = 0;
		flip = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: translate by zero
		send_vertex(make_vertex(16'sh8000, 16'sh7fff, 1'b1), 0);
		send_vertex(make_vertex(16'sh7fff, 16'sh8000, 1'b0), 2);
		send_vertex(make_vertex(16'sh0000, -16'sd1, 1'b1), 0);
		drain();

		// Scale with the factors still at reset
		apb_write(REG_OPERATION, 32'(OP_SCALE));
		send_vertex(make_vertex(16'sh8000, 16'sh7fff, 1'b0), 0);
		send_vertex(make_vertex(16'sd1234, -16'sd1, 1'b1), 0);
		drain();

		// Translate by the extreme offsets
		apb_write(REG_OFFSET_X, 32'sh7fff);
		apb_write(REG_OFFSET_Y, -32'sd32768);
		apb_write(REG_OPERATION, 32'(OP_TRANSLATE));
		send_vertex(make_vertex(16'sh7fff, 16'sh8000, 1'b0), 0);
		send_vertex(make_vertex(16'sh8000, 16'sh7fff, 1'b1), 1);
		drain();

		// Scale by the most negative factor
		apb_write(REG_FACTOR_X, -32'sd32768);
		apb_write(REG_FACTOR_Y, -32'sd32768);
		apb_write(REG_OPERATION, 32'(OP_SCALE));
		send_vertex(make_vertex(16'sh8000, 16'sh8000, 1'b0), 0);
		send_vertex(make_vertex(16'sh7fff, 16'sh7fff, 1'b1), 0);
		drain();

		// Rotate with the angle still at reset
		apb_write(REG_OPERATION, 32'(OP_ROTATE));
		send_vertex(make_vertex(16'sh8000, 16'sh7fff, 1'b1), 0);
		drain();

		// Quadrant boundaries, an odd angle, and angles that wrap past a full turn
		foreach (angles[k]) begin
			apb_write(REG_ANGLE_DEG, angles[k]);
			if (flip)
				send_vertex(make_vertex(16'sd12345, -16'sd321, 1'b0), 0);
			else
				send_vertex(make_vertex(16'sh8000, 16'sh7fff, 1'b1), 0);
			flip = !flip;
			drain();
		end

		// Spare register slots, then the unused operation code
		apb_write(REG_SPARE_6, $urandom);
		apb_write(REG_SPARE_7, $urandom);
		apb_write(REG_OPERATION, 32'(OP_PASS));
		send_vertex(make_vertex(16'sh8000, 16'sh7fff, 1'b0), 0);
		send_vertex(make_vertex(16'sh7fff, 16'sh8000, 1'b1), 0);
		drain();

		directed_items = sb.op_count[0] + sb.op_count[1] + sb.op_count[2] + sb.op_count[3];
		sent = directed_items;

		// Random phases: new settings, then a batch of vertices
		while (sent < directed_items + RANDOM_ITEMS) begin
			drain();
			c = random_setting();
			program_regs(c);
			settings++;
			burst = ($urandom_range(0, 3) == 0);
			phase_items = $urandom_range(30, 200);
			for (int i = 0; i < phase_items; i++) begin
				send_vertex(make_vertex(rand_coord(), rand_coord(), 1'($urandom_range(0, 1))),
					burst ? 0 : gap_cycles());
				sent++;
				// occasionally hold off until the pipeline is empty
				if ($urandom_range(0, 99) == 0)
					drain();
			end
		end

		drain();
		repeat (LATENCY + 4) @(posedge clk);

		$display("Covered %0d vertices under %0d random settings plus directed extremes:",
			sent, settings);
		$display("  translate %0d, scale %0d, rotate %0d, pass-through %0d; %0d results, %0d errors",
			sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3], sb.checked,
			sb.errors);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
